>>> rtl/outgoing_item_state_tracker_assert.svh
// ----------------------------------------------------------------------------
// outgoing_item_state_tracker_assert.svh
// assertion macros used by the tracker rtl
// ----------------------------------------------------------------------------
`ifndef OUTGOING_ITEM_STATE_TRACKER_ASSERT_SVH
`define OUTGOING_ITEM_STATE_TRACKER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define OIST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("oist assertion failed");

// next-cycle implication, disabled while reset is asserted
`define OIST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("oist assertion failed");

`endif

>>> rtl/oist_pkg.sv
// ----------------------------------------------------------------------------
// oist_pkg
// types, constants and helpers of the outgoing item state tracker
// ----------------------------------------------------------------------------
`default_nettype none

package oist_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W = 32;
	localparam int SLOT_W = 4;
	localparam int CODE_W = 3;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	localparam logic [CODE_W-1:0] STATE_EMPTY = 3'd0;
	localparam logic [CODE_W-1:0] STATE_PENDING = 3'd1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WALK,
		ST_UPD,
		ST_RESP
	} fsm_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic do_start;
		logic rd_first;
		logic walk_next;
		logic set_found;
		logic do_update;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic rd_empty;
		logic rd_match;
		logic walk_last;
		logic slot_ok;
	} status_t;

	function automatic idx_t prev_idx(input idx_t i);
		idx_t r;
		if (i == '0) begin
			r = IDX_W'(DEPTH - 1);
		end else begin
			r = i - 1'b1;
		end
		return r;
	endfunction

	function automatic idx_t next_idx(input idx_t i);
		idx_t r;
		if (i == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/outgoing_item_state_tracker.sv
// ----------------------------------------------------------------------------
// outgoing_item_state_tracker
// ring of tracking slots holding id and state code of outgoing items
//
//   channel   handshake          payload
//   command   start / busy       mode, instance_id, slot_index, new_state
//   result    done (strobe)      assigned_slot, updated, found, state_code
//
// done is raised in the response state, reached via the issue state for start
// and unused modes, issue and update check for update, and issue plus one walk
// state per slot read (at most DEPTH) for a query, as the walk reads the slot
// memory one entry per cycle; busy drops the cycle after done
// reset clears the head and the per-slot valid bits at once, no sweep
// the result is shown for one cycle and cannot be held off
// ----------------------------------------------------------------------------
`default_nettype none

`include "outgoing_item_state_tracker_assert.svh"

module outgoing_item_state_tracker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [oist_pkg::MODE_W-1:0] mode,
	input wire logic [oist_pkg::ID_W-1:0] instance_id,
	input wire logic [oist_pkg::SLOT_W-1:0] slot_index,
	input wire logic [oist_pkg::CODE_W-1:0] new_state,
	output logic done,
	output logic [oist_pkg::SLOT_W-1:0] assigned_slot,
	output logic updated,
	output logic found,
	output logic [oist_pkg::CODE_W-1:0] state_code
);

	oist_pkg::cmd_t cmd;
	oist_pkg::status_t sts;

	oist_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.sts(sts),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	oist_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.mode(mode),
		.instance_id(instance_id),
		.slot_index(slot_index),
		.new_state(new_state),
		.assigned_slot(assigned_slot),
		.updated(updated),
		.found(found),
		.state_code(state_code)
	);

	`OIST_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`OIST_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy && !done)
	`OIST_ASSERT_NOW(a_one_flag, clk, arst_n, done, !(found && updated))
	`OIST_ASSERT_NOW(a_found_code, clk, arst_n, done && found, state_code != oist_pkg::STATE_EMPTY)

endmodule

`default_nettype wire

>>> rtl/oist_dp.sv
// ----------------------------------------------------------------------------
// oist_dp
// slot memory, ring head, walk pointer and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module oist_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire oist_pkg::cmd_t cmd,
	output oist_pkg::status_t sts,
	input wire logic [oist_pkg::MODE_W-1:0] mode,
	input wire logic [oist_pkg::ID_W-1:0] instance_id,
	input wire logic [oist_pkg::SLOT_W-1:0] slot_index,
	input wire logic [oist_pkg::CODE_W-1:0] new_state,
	output logic [oist_pkg::SLOT_W-1:0] assigned_slot,
	output logic updated,
	output logic found,
	output logic [oist_pkg::CODE_W-1:0] state_code
);

	logic [oist_pkg::MODE_W-1:0] mode_q;
	logic [oist_pkg::ID_W-1:0] id_q;
	logic [oist_pkg::SLOT_W-1:0] slot_q;
	logic [oist_pkg::CODE_W-1:0] nstate_q;

	oist_pkg::idx_t head_q;
	oist_pkg::idx_t idx_q;
	logic [oist_pkg::CNT_W-1:0] cnt_q;
	oist_pkg::entry_t rd_q;

	oist_pkg::entry_t mem [oist_pkg::DEPTH];
	logic [oist_pkg::DEPTH-1:0] valid_q;

	logic [oist_pkg::SLOT_W-1:0] assigned_q;
	logic updated_q;
	logic found_q;
	logic [oist_pkg::CODE_W-1:0] code_q;

	oist_pkg::idx_t slot_addr;
	oist_pkg::idx_t rd_addr;
	oist_pkg::idx_t wr_addr;
	oist_pkg::entry_t wr_data;
	logic rd_en;
	logic wr_en;

	always_comb begin
		slot_addr = oist_pkg::IDX_W'(slot_q);
		rd_en = cmd.rd_first | cmd.walk_next;
		if (cmd.rd_first) begin
			rd_addr = (mode_q == oist_pkg::MODE_UPDATE) ? slot_addr
				: oist_pkg::prev_idx(head_q);
		end else begin
			rd_addr = oist_pkg::prev_idx(idx_q);
		end
		wr_en = cmd.do_start | cmd.do_update;
		wr_addr = cmd.do_start ? head_q : slot_addr;
		wr_data.id = id_q;
		wr_data.code = cmd.do_start ? oist_pkg::STATE_PENDING : nstate_q;
	end

	// inputs held for the whole operation
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			id_q <= instance_id;
			slot_q <= slot_index;
			nstate_q <= new_state;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// entries never written read as empty with id zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
			idx_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.do_start) begin
				head_q <= oist_pkg::next_idx(head_q);
			end
			if (cmd.rd_first) begin
				cnt_q <= '0;
			end else if (cmd.walk_next) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			assigned_q <= '0;
			updated_q <= 1'b0;
			found_q <= 1'b0;
			code_q <= '0;
		end else begin
			if (cmd.do_start) begin
				assigned_q <= oist_pkg::SLOT_W'(head_q);
			end
			if (cmd.do_update) begin
				updated_q <= 1'b1;
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
				code_q <= rd_q.code;
			end
		end
	end

	always_comb begin
		sts.mode = mode_q;
		sts.rd_empty = (rd_q.code == oist_pkg::STATE_EMPTY);
		sts.rd_match = (rd_q.id == id_q);
		sts.walk_last = (cnt_q == oist_pkg::CNT_W'(oist_pkg::DEPTH - 1));
		sts.slot_ok = (32'(slot_q) < 32'(oist_pkg::DEPTH));
	end

	assign assigned_slot = assigned_q;
	assign updated = updated_q;
	assign found = found_q;
	assign state_code = code_q;

endmodule

`default_nettype wire

>>> rtl/oist_ctrl.sv
// ----------------------------------------------------------------------------
// oist_ctrl
// operation sequencer: issue, slot walk, update check and response
// ----------------------------------------------------------------------------
`default_nettype none

module oist_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire oist_pkg::status_t sts,
	output oist_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);

	oist_pkg::fsm_t state_q;
	oist_pkg::fsm_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oist_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oist_pkg::ST_IDLE: begin
				if (start) begin
					state_d = oist_pkg::ST_ISSUE;
				end
			end
			oist_pkg::ST_ISSUE: begin
				case (sts.mode)
					oist_pkg::MODE_UPDATE: state_d = oist_pkg::ST_UPD;
					oist_pkg::MODE_QUERY: state_d = oist_pkg::ST_WALK;
					default: state_d = oist_pkg::ST_RESP;
				endcase
			end
			oist_pkg::ST_WALK: begin
				if (sts.rd_empty || sts.rd_match || sts.walk_last) begin
					state_d = oist_pkg::ST_RESP;
				end
			end
			oist_pkg::ST_UPD: state_d = oist_pkg::ST_RESP;
			oist_pkg::ST_RESP: state_d = oist_pkg::ST_IDLE;
			default: state_d = oist_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			oist_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
			end
			oist_pkg::ST_ISSUE: begin
				cmd.do_start = (sts.mode == oist_pkg::MODE_START);
				cmd.rd_first = (sts.mode == oist_pkg::MODE_UPDATE)
					|| (sts.mode == oist_pkg::MODE_QUERY);
			end
			oist_pkg::ST_WALK: begin
				// an empty slot ends the walk before any id compare
				cmd.set_found = !sts.rd_empty && sts.rd_match;
				cmd.walk_next = !sts.rd_empty && !sts.rd_match && !sts.walk_last;
			end
			oist_pkg::ST_UPD: begin
				cmd.do_update = sts.slot_ok && sts.rd_match;
			end
			oist_pkg::ST_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> tb/outgoing_item_state_tracker_tb.sv
// ----------------------------------------------------------------------------
// outgoing_item_state_tracker_tb
// self-checking bench for the outgoing item state tracker
//
// a driver offers command beats from a queue on start / busy, a shadow ring
// of slots predicts every result at accept time, and a monitor compares each
// done strobe against the oldest prediction. a directed opening covers the
// empty ring, the unused mode, updates to empty and the head wrap, then
// random start/update/query/unused traffic with random gaps and a few pauses
// that let the tracker drain completely
// ----------------------------------------------------------------------------
module outgoing_item_state_tracker_tb;

	import oist_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 500;
	localparam int MAX_GAP = 6;
	localparam int TAIL_CYCLES = DEPTH + 24;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0] id;
		logic [SLOT_W-1:0] slot;
		logic [CODE_W-1:0] code;
		int gap;
		bit drain;
	} command_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic upd;
		logic fnd;
		logic [CODE_W-1:0] code;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [MODE_W-1:0] mode = '0;
	logic [ID_W-1:0] instance_id = '0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic [CODE_W-1:0] new_state = '0;
	logic done;
	logic [SLOT_W-1:0] assigned_slot;
	logic updated;
	logic found;
	logic [CODE_W-1:0] state_code;

	// shadow of the tracking ring
	logic [ID_W-1:0] trk_id [DEPTH];
	logic [CODE_W-1:0] trk_code [DEPTH];
	idx_t trk_head;

	// ids handed out while building the stimulus, so updates and queries can hit
	logic [ID_W-1:0] plan_ids [DEPTH];
	int plan_head;
	bit calm;

	command_t command_q[$];
	outcome_t pending_results[$];
	command_t cur_cmd;
	bit have_cmd = 1'b0;
	int gap_left = 0;

	int accepted_cnt = 0;
	int done_cnt = 0;
	int fail_cnt = 0;
	int n_start = 0;
	int n_update = 0;
	int n_upd_hit = 0;
	int n_query = 0;
	int n_found = 0;
	int n_unused = 0;

	outgoing_item_state_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.instance_id(instance_id),
		.slot_index(slot_index),
		.new_state(new_state),
		.done(done),
		.assigned_slot(assigned_slot),
		.updated(updated),
		.found(found),
		.state_code(state_code)
	);

	always #5 clk = ~clk;

	task automatic clear_tracker();
		for (int s = 0; s < DEPTH; s++) begin
			trk_id[s] = '0;
			trk_code[s] = STATE_EMPTY;
			plan_ids[s] = '0;
		end
		trk_head = '0;
		plan_head = 0;
	endtask

	// apply one accepted beat to the shadow ring and queue its result
	task automatic apply_tracker_op(input command_t c);
		outcome_t o;
		idx_t i;
		int n;
		bit walking;
		o = '0;
		case (c.mode)
			MODE_START: begin
				n_start++;
				trk_id[trk_head] = c.id;
				trk_code[trk_head] = STATE_PENDING;
				o.slot = SLOT_W'(trk_head);
				trk_head = (trk_head == idx_t'(DEPTH - 1)) ? '0 : trk_head + 1'b1;
			end
			MODE_UPDATE: begin
				n_update++;
				if (int'(c.slot) < DEPTH && trk_id[c.slot] == c.id) begin
					trk_code[c.slot] = c.code;
					o.upd = 1'b1;
					n_upd_hit++;
				end
			end
			MODE_QUERY: begin
				n_query++;
				// newest first, stop at the first empty slot or after a full lap
				i = (trk_head == '0) ? idx_t'(DEPTH - 1) : trk_head - 1'b1;
				n = 0;
				walking = 1'b1;
				while (walking && n < DEPTH) begin
					if (trk_code[i] == STATE_EMPTY) begin
						walking = 1'b0;
					end else if (trk_id[i] == c.id) begin
						o.fnd = 1'b1;
						o.code = trk_code[i];
						walking = 1'b0;
					end else begin
						i = (i == '0) ? idx_t'(DEPTH - 1) : i - 1'b1;
						n++;
					end
				end
				if (o.fnd) begin
					n_found++;
				end
			end
			default: begin
				n_unused++;
			end
		endcase
		pending_results.push_back(o);
	endtask

	task automatic add_command(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
			input logic [SLOT_W-1:0] s, input logic [CODE_W-1:0] c, input bit drain);
		command_t cmd;
		cmd.mode = m;
		cmd.id = id;
		cmd.slot = s;
		cmd.code = c;
		cmd.gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		cmd.drain = drain;
		if (m == MODE_START) begin
			plan_ids[plan_head] = id;
			plan_head = (plan_head + 1) % DEPTH;
		end
		command_q.push_back(cmd);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		logic [ID_W-1:0] id;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: id = plan_ids[idx_t'($urandom_range(0, DEPTH - 1))];
			6: begin
				case ($urandom_range(0, 3))
					0: id = '0;
					1: id = '1;
					2: id = 32'h8000_0000;
					default: id = 32'h0000_0001;
				endcase
			end
			default: id = $urandom;
		endcase
		return id;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_commands
		bit go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				apply_tracker_op(cur_cmd);
				accepted_cnt++;
				have_cmd = 1'b0;
			end
			if (!have_cmd && command_q.size() > 0) begin
				cur_cmd = command_q.pop_front();
				have_cmd = 1'b1;
				gap_left = cur_cmd.gap;
			end
			go = 1'b0;
			if (have_cmd) begin
				if (start && busy) begin
					go = 1'b1;
				end else if (gap_left > 0) begin
					gap_left--;
				end else if (!cur_cmd.drain || accepted_cnt == done_cnt) begin
					// a drain beat holds off until every result is back
					go = 1'b1;
				end
			end
			start <= go;
			if (go) begin
				mode <= cur_cmd.mode;
				instance_id <= cur_cmd.id;
				slot_index <= cur_cmd.slot;
				new_state <= cur_cmd.code;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			done_cnt <= 0;
		end else if (done) begin
			done_cnt <= done_cnt + 1;
			got = {assigned_slot, updated, found, state_code};
			if (pending_results.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= REPORT_LIMIT) begin
					$display("unexpected result: slot %0d updated %0b found %0b state %0d",
						got.slot, got.upd, got.fnd, got.code);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_LIMIT) begin
						$display("result %0d slot/upd/found/state: expected %0d/%0b/%0b/%0d",
							done_cnt, want.slot, want.upd, want.fnd, want.code);
						$display("  got %0d/%0b/%0b/%0d",
							got.slot, got.upd, got.fnd, got.code);
					end
				end
			end
		end
	end

	initial begin : run
		int r;
		logic [SLOT_W-1:0] s;
		logic [CODE_W-1:0] c;
		clear_tracker();
		calm = 1'b0;

		// empty ring, unused mode, update hitting the reset id of zero
		add_command(MODE_QUERY, '0, '0, '0, 1'b0);
		add_command(MODE_UNUSED, '1, '1, '1, 1'b0);
		add_command(MODE_UPDATE, '0, 4'd5, 3'd7, 1'b0);
		add_command(MODE_START, '1, '0, '0, 1'b0);
		add_command(MODE_START, '0, '1, '1, 1'b0);
		add_command(MODE_QUERY, '1, '0, '0, 1'b0);
		add_command(MODE_UPDATE, '1, 4'd0, 3'd7, 1'b0);
		add_command(MODE_QUERY, '1, '1, '1, 1'b0);
		// emptying the newest slot cuts every walk short
		add_command(MODE_UPDATE, '0, 4'd1, STATE_EMPTY, 1'b0);
		add_command(MODE_QUERY, '1, '0, '0, 1'b1);
		// fill the rest of the ring and wrap the head
		for (int k = 2; k < DEPTH; k++) begin
			add_command(MODE_START, 32'h1000_0000 + k, SLOT_W'(k), CODE_W'(k), 1'b0);
		end
		add_command(MODE_START, 32'hA5A5_5A5A, '0, '0, 1'b0);
		add_command(MODE_QUERY, 32'h7FFF_FFFF, '0, '0, 1'b1);

		for (int k = 0; k < RANDOM_BEATS; k++) begin
			if (k % 50 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
			r = $urandom_range(0, 99);
			s = SLOT_W'($urandom);
			c = CODE_W'($urandom);
			if (r < 35) begin
				add_command(MODE_START, ($urandom_range(0, 3) == 0) ? pick_id() : $urandom,
					s, c, k % 125 == 124);
			end else if (r < 60) begin
				c = ($urandom_range(0, 9) == 0) ? STATE_EMPTY : CODE_W'($urandom_range(1, 7));
				add_command(MODE_UPDATE,
					($urandom_range(0, 9) < 7) ? plan_ids[s] : pick_id(), s, c, k % 125 == 124);
			end else if (r < 95) begin
				add_command(MODE_QUERY, pick_id(), s, c, k % 125 == 124);
			end else begin
				add_command(MODE_UNUSED, $urandom, s, c, k % 125 == 124);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (command_q.size() != 0 || have_cmd || start || accepted_cnt != done_cnt) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			fail_cnt += pending_results.size();
		end

		$display("%0d beats: %0d start, %0d update (%0d hit), %0d query (%0d hit), %0d unused",
			accepted_cnt, n_start, n_update, n_upd_hit, n_query, n_found, n_unused);
		$display("checked %0d results, %0d failures", done_cnt, fail_cnt);
		if (fail_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("status: fail");
		$finish;
	end

endmodule

>>> outgoing_item_state_tracker.f
+incdir+rtl
rtl/oist_pkg.sv
rtl/oist_dp.sv
rtl/oist_ctrl.sv
rtl/outgoing_item_state_tracker.sv
tb/outgoing_item_state_tracker_tb.sv
